// File: sv/mrtu_pkg.sv
package mrtu_pkg;

   // Default limit on the response frame length in bytes.
   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 256;

   // Input item kinds.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_RX    = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Result item kinds.
   localparam logic [1:0] OUT_TX     = 2'd0;
   localparam logic [1:0] OUT_DATA   = 2'd1;
   localparam logic [1:0] OUT_STATUS = 2'd2;

   // Final status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_COUNT = 3'd1;
   localparam logic [2:0] ST_ADDRESS   = 3'd2;
   localparam logic [2:0] ST_EXCEPTION = 3'd3;
   localparam logic [2:0] ST_FUNCTION  = 3'd4;
   localparam logic [2:0] ST_CRC       = 3'd5;
   localparam logic [2:0] ST_TIMEOUT   = 3'd6;
   localparam logic [2:0] ST_TOO_LONG  = 3'd7;

   // Modbus function codes.
   localparam logic [7:0] FN_READ       = 8'h03;
   localparam logic [7:0] FN_WRITE      = 8'h06;
   localparam logic [7:0] FN_EXCEPT_BIT = 8'h80;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // One byte of CRC-16/MODBUS, reflected, eight shift steps.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/modbus_rtu_master_transaction.sv
// A start item arms the byte sequencer, which then loads one request byte per cycle into the
// result register while the output is free (eight bytes, plus the too-long status).
// The input stays stalled until the last of those is loaded.
// A received byte or end item's result (if any) is registered at the edge it is taken and
// offered the next cycle; such items can follow back to back at one per cycle while unstalled.
// Reset (synchronous, active high) closes any transaction, empties the result register and
// sets the device address to 1.
module modbus_rtu_master_transaction #(
   parameter int unsigned MAX_FRAME_BYTES = mrtu_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic        req_operation,
   input  logic [15:0] req_reg_address,
   input  logic [15:0] req_operand_word,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_tx_last,
   output logic [2:0]  rsp_status,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_device_address
);
   import mrtu_pkg::*;

   // Width that holds any allowed frame length, and one more bit for position compares.
   localparam int unsigned LEN_WIDTH = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned CMP_WIDTH = LEN_WIDTH + 1;

   // Request sequencer positions: six header bytes, CRC low, CRC high, then the
   // optional too-long status.
   localparam logic [3:0] TX_IDX_FIRST  = 4'd0;
   localparam logic [3:0] TX_IDX_CRC_LO = 4'd6;
   localparam logic [3:0] TX_IDX_CRC_HI = 4'd7;
   localparam logic [3:0] TX_IDX_STATUS = 4'd8;

   localparam logic [LEN_WIDTH-1:0] WRITE_RSP_LEN = LEN_WIDTH'(8);
   localparam logic [LEN_WIDTH-1:0] READ_RSP_OVERHEAD = LEN_WIDTH'(5);

   // Configuration register. The address is latched into the request at start,
   // so a later write only affects the next transaction.
   logic [7:0] device_address_ff;

   // Transaction state.
   logic                 busy_ff,      busy_in;
   logic                 is_write_ff,  is_write_in;
   logic [7:0]           request_bytes_ff [6];
   logic [LEN_WIDTH-1:0] byte_position_ff,   byte_position_in;
   logic [LEN_WIDTH-1:0] expected_length_ff, expected_length_in;
   logic [15:0]          running_crc_ff,     running_crc_in;
   logic [7:0]           captured_header_ff [3];
   logic [7:0]           crc_low_byte_ff;
   logic                 echo_matches_ff,    echo_matches_in;

   // Request byte sequencer.
   logic        tx_active_ff,   tx_active_in;
   logic [3:0]  tx_index_ff,    tx_index_in;
   logic [15:0] tx_crc_ff,      tx_crc_in;
   logic        tx_too_long_ff, tx_too_long_in;

   // Result register.
   logic       rsp_valid_ff,    rsp_valid_in;
   logic [1:0] rsp_out_kind_ff, rsp_out_kind_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_tx_last_ff,  rsp_tx_last_in;
   logic [2:0] rsp_status_ff,   rsp_status_in;

   logic out_free;
   logic req_accept;
   logic rsp_load;

   // Start decode.
   logic [17:0]          read_len_full;
   logic                 start_too_long;
   logic [LEN_WIDTH-1:0] start_len;

   // Received byte decode.
   logic [CMP_WIDTH-1:0] pos_plus2;
   logic [CMP_WIDTH-1:0] len_ext;
   logic                 rx_body;
   logic                 rx_crc_lo;
   logic                 rx_final;
   logic                 header_pos;
   logic                 echo_pos;
   logic [7:0]           expect_fn;
   logic [15:0]          rx_crc_word;
   logic [7:0]           expect_count;
   logic [2:0]           final_status;
   logic [7:0]           tx_byte;

   // The result register moves whenever it is empty or being taken. Input items are
   // held off while the request frame is being sent, since each start makes eight or
   // nine results and only one can leave per cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = tx_active_ff || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = rsp_out_kind_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_tx_last  = rsp_tx_last_ff;
   assign rsp_status   = rsp_status_ff;

   // Response length for a read is 5 + 2 * count; anything over the frame limit
   // ends the transaction right after the request is sent.
   assign read_len_full  = {1'b0, req_operand_word, 1'b0} + 18'd5;
   assign start_too_long = !req_operation && (read_len_full > 18'(MAX_FRAME_BYTES));
   assign start_len      = req_operation ? WRITE_RSP_LEN : LEN_WIDTH'(read_len_full);

   // Classify the received byte by position: body bytes feed the CRC, the second to
   // last is the CRC low byte, and the last one closes the frame.
   assign pos_plus2  = {1'b0, byte_position_ff} + CMP_WIDTH'(2);
   assign len_ext    = {1'b0, expected_length_ff};
   assign rx_body    = pos_plus2 < len_ext;
   assign rx_crc_lo  = pos_plus2 == len_ext;
   assign rx_final   = !rx_body && !rx_crc_lo;
   assign header_pos = byte_position_ff < LEN_WIDTH'(3);
   assign echo_pos   = byte_position_ff < LEN_WIDTH'(6);

   assign expect_fn    = is_write_ff ? FN_WRITE : FN_READ;
   assign rx_crc_word  = {req_rx_byte, crc_low_byte_ff};
   assign expect_count = 8'(expected_length_ff - READ_RSP_OVERHEAD);

   // Final checks in priority order: address, exception, function, CRC, then byte
   // count for a read or the echo for a write.
   always_comb begin
      if (captured_header_ff[0] != request_bytes_ff[0]) begin
         final_status = ST_ADDRESS;
      end else if (captured_header_ff[1] == (expect_fn | FN_EXCEPT_BIT)) begin
         final_status = ST_EXCEPTION;
      end else if (captured_header_ff[1] != expect_fn) begin
         final_status = ST_FUNCTION;
      end else if (rx_crc_word != running_crc_ff) begin
         final_status = ST_CRC;
      end else if (is_write_ff) begin
         final_status = echo_matches_ff ? ST_OK : ST_BAD_COUNT;
      end else begin
         final_status = (captured_header_ff[2] == expect_count) ? ST_OK : ST_BAD_COUNT;
      end
   end

   // Byte the sequencer sends at its current position.
   always_comb begin
      if (tx_index_ff < TX_IDX_CRC_LO) begin
         tx_byte = request_bytes_ff[tx_index_ff[2:0]];
      end else if (tx_index_ff == TX_IDX_CRC_LO) begin
         tx_byte = tx_crc_ff[7:0];
      end else begin
         tx_byte = tx_crc_ff[15:8];
      end
   end

   always_comb begin
      busy_in            = busy_ff;
      is_write_in        = is_write_ff;
      byte_position_in   = byte_position_ff;
      expected_length_in = expected_length_ff;
      running_crc_in     = running_crc_ff;
      echo_matches_in    = echo_matches_ff;

      tx_active_in   = tx_active_ff;
      tx_index_in    = tx_index_ff;
      tx_crc_in      = tx_crc_ff;
      tx_too_long_in = tx_too_long_ff;

      rsp_load        = 1'b0;
      rsp_out_kind_in = rsp_out_kind_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_tx_last_in  = rsp_tx_last_ff;
      rsp_status_in   = rsp_status_ff;

      if (tx_active_ff && out_free) begin
         // Send one request byte, folding the header bytes into the CRC as they go.
         rsp_load        = 1'b1;
         rsp_out_kind_in = OUT_TX;
         rsp_out_byte_in = tx_byte;
         rsp_tx_last_in  = tx_index_ff == TX_IDX_CRC_HI;
         rsp_status_in   = ST_OK;
         if (tx_index_ff < TX_IDX_CRC_LO) begin
            tx_crc_in = crc16_update(tx_crc_ff, tx_byte);
         end
         if (tx_index_ff == TX_IDX_STATUS) begin
            rsp_out_kind_in = OUT_STATUS;
            rsp_out_byte_in = 8'h00;
            rsp_tx_last_in  = 1'b0;
            rsp_status_in   = ST_TOO_LONG;
            tx_active_in    = 1'b0;
         end else if (tx_index_ff == TX_IDX_CRC_HI && !tx_too_long_ff) begin
            tx_active_in = 1'b0;
         end
         tx_index_in = tx_index_ff + 4'd1;
      end

      if (req_accept) begin
         case (req_kind)
            KIND_START: begin
               // A start drops any open transaction without a status.
               is_write_in        = req_operation;
               byte_position_in   = '0;
               running_crc_in     = CRC_INIT;
               echo_matches_in    = 1'b1;
               busy_in            = !start_too_long;
               expected_length_in = start_too_long ? '0 : start_len;
               tx_active_in       = 1'b1;
               tx_index_in        = TX_IDX_FIRST;
               tx_crc_in          = CRC_INIT;
               tx_too_long_in     = start_too_long;
            end
            KIND_RX: begin
               if (busy_ff) begin
                  if (is_write_ff && echo_pos &&
                      req_rx_byte != request_bytes_ff[byte_position_ff[2:0]]) begin
                     echo_matches_in = 1'b0;
                  end
                  if (rx_body) begin
                     running_crc_in = crc16_update(running_crc_ff, req_rx_byte);
                     if (!is_write_ff && !header_pos) begin
                        rsp_load        = 1'b1;
                        rsp_out_kind_in = OUT_DATA;
                        rsp_out_byte_in = req_rx_byte;
                        rsp_tx_last_in  = 1'b0;
                        rsp_status_in   = ST_OK;
                     end
                  end else if (rx_final) begin
                     rsp_load        = 1'b1;
                     rsp_out_kind_in = OUT_STATUS;
                     rsp_out_byte_in = 8'h00;
                     rsp_tx_last_in  = 1'b0;
                     rsp_status_in   = final_status;
                     busy_in         = 1'b0;
                  end
                  byte_position_in = byte_position_ff + LEN_WIDTH'(1);
               end
            end
            KIND_END: begin
               if (busy_ff) begin
                  rsp_load        = 1'b1;
                  rsp_out_kind_in = OUT_STATUS;
                  rsp_out_byte_in = 8'h00;
                  rsp_tx_last_in  = 1'b0;
                  rsp_status_in   = ST_TIMEOUT;
                  busy_in         = 1'b0;
               end
            end
            default: begin
               // The unused kind is taken and dropped.
            end
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff  <= 8'h01;
         busy_ff            <= 1'b0;
         is_write_ff        <= 1'b0;
         byte_position_ff   <= '0;
         expected_length_ff <= '0;
         running_crc_ff     <= CRC_INIT;
         echo_matches_ff    <= 1'b1;
         tx_active_ff       <= 1'b0;
         tx_index_ff        <= TX_IDX_FIRST;
         tx_crc_ff          <= CRC_INIT;
         tx_too_long_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            device_address_ff <= csr_device_address;
         end
         busy_ff            <= busy_in;
         is_write_ff        <= is_write_in;
         byte_position_ff   <= byte_position_in;
         expected_length_ff <= expected_length_in;
         running_crc_ff     <= running_crc_in;
         echo_matches_ff    <= echo_matches_in;
         tx_active_ff       <= tx_active_in;
         tx_index_ff        <= tx_index_in;
         tx_crc_ff          <= tx_crc_in;
         tx_too_long_ff     <= tx_too_long_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload registers: the request copy, captured header and result fields.
   always_ff @(posedge clock) begin
      if (req_accept && req_kind == KIND_START) begin
         request_bytes_ff[0] <= device_address_ff;
         request_bytes_ff[1] <= req_operation ? FN_WRITE : FN_READ;
         request_bytes_ff[2] <= req_reg_address[15:8];
         request_bytes_ff[3] <= req_reg_address[7:0];
         request_bytes_ff[4] <= req_operand_word[15:8];
         request_bytes_ff[5] <= req_operand_word[7:0];
      end
      if (req_accept && req_kind == KIND_RX && busy_ff) begin
         if (header_pos) begin
            captured_header_ff[byte_position_ff[1:0]] <= req_rx_byte;
         end
         if (rx_crc_lo) begin
            crc_low_byte_ff <= req_rx_byte;
         end
      end
      rsp_out_kind_ff <= rsp_out_kind_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_tx_last_ff  <= rsp_tx_last_in;
      rsp_status_ff   <= rsp_status_in;
   end

   // While a response is open the position never reaches the expected length.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (byte_position_ff < expected_length_ff))
      else $error("byte position ran past the expected response length");

   // Read data results only come from a read transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_out_kind_ff == OUT_DATA) |-> !is_write_ff)
      else $error("data byte emitted for a write transaction");

   // The last-byte mark only rides on a transmit result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tx_last_ff) |-> (rsp_out_kind_ff == OUT_TX && !tx_active_ff) ||
                                          (rsp_out_kind_ff == OUT_TX && tx_too_long_ff))
      else $error("frame end mark on a wrong result");

   // A start always sends its first request byte on the next cycle the output is free.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_START) |=> (tx_active_ff && tx_index_ff == TX_IDX_FIRST))
      else $error("start did not arm the request sequencer");

endmodule
